// ----- sv/fifo_lock_manager_macros.svh -----
// Assertion macros used by the lock manager checker.
// Each macro samples on clk and is disabled while rst is high.
`ifndef FIFO_LOCK_MANAGER_MACROS_SVH
`define FIFO_LOCK_MANAGER_MACROS_SVH

// Same-cycle implication.
`define FLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FLM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/flm_pkg.sv -----
// Shared types and constants of the FIFO lock manager.
// No dependencies.
`default_nettype none
package flm_pkg;
  localparam int NUM_SLOTS_DEF   = 256;
  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int KEY_W    = 16;
  localparam int NODE_W   = 8;
  localparam int STATUS_W = 3;
  localparam int LEFT_W   = 6;
  localparam int LEFT_MAX = 63;

  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED    = 3'd0,
    STAT_QUEUED     = 3'd1,
    STAT_PASSED     = 3'd2,
    STAT_FREED      = 3'd3,
    STAT_NOT_HOLDER = 3'd4,
    STAT_NOT_FOUND  = 3'd5,
    STAT_TABLE_FULL = 3'd6,
    STAT_QUEUE_FULL = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_POP,
    ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- sv/flm_ram.sv -----
// Single-port-write, single-port-read RAM with registered read data.
// Used for the slot table and the waiter store; no package dependency.
`default_nettype none
module flm_ram #(
  parameter int W  = 8,
  parameter int D  = 256,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/fifo_lock_manager.sv -----
// Lock manager: one request or release word in on the input channel, one
// status word out on the output channel. Both channels use valid/stall; a
// word moves at a clock edge with valid high and stall low.
// An item walks the claimed slots one per cycle through the slot RAM, with
// the key comparator as the shared unit. A release that hands off to a
// waiter goes through the extra POP state for the waiter RAM read. in_stall
// is high from acceptance until the result has moved into the output
// register. Slots are claimed in order and never freed, so a claimed-slot
// count stands in for per-slot valid bits and no clearing pass runs after
// reset: the block takes a word in the first cycle after rst. Reset empties
// the table and drops any pending result. While the receiver holds
// out_stall, the result word stays put and the next item can still be
// accepted and worked on; it waits in its final state for the register.
`default_nettype none
module fifo_lock_manager #(
  parameter int NUM_SLOTS   = flm_pkg::NUM_SLOTS_DEF,
  parameter int QUEUE_DEPTH = flm_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          action,
  input  wire logic [flm_pkg::KEY_W-1:0]     lock_key,
  input  wire logic [flm_pkg::NODE_W-1:0]    node,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [flm_pkg::STATUS_W-1:0]  status,
  output logic                               grant_valid,
  output logic      [flm_pkg::NODE_W-1:0]    grant_node,
  output logic      [flm_pkg::LEFT_W-1:0]    waiters_left
);
  import flm_pkg::*;

  localparam int SW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FILL_W = $clog2(NUM_SLOTS + 1);
  localparam int QIW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW     = $clog2(QUEUE_DEPTH + 1);
  localparam int SUMW   = CW + 1;
  localparam int WD     = NUM_SLOTS * QUEUE_DEPTH;
  localparam int WAW    = (WD > 1) ? $clog2(WD) : 1;
  localparam int REC_W  = KEY_W + 1 + NODE_W + QIW + CW;

  state_t state, state_next;

  logic                act, act_next;
  logic [KEY_W-1:0]    req_key, req_key_next;
  logic [NODE_W-1:0]   req_node, req_node_next;
  logic [FILL_W-1:0]   fill, fill_next;
  logic [FILL_W-1:0]   scan_idx, scan_idx_next;
  logic                pend, pend_next;
  logic [SW-1:0]       cmp_idx, cmp_idx_next;
  logic [SW-1:0]       slot, slot_next;
  logic [KEY_W-1:0]    r_key, r_key_next;
  logic                r_held, r_held_next;
  logic [NODE_W-1:0]   r_holder, r_holder_next;
  logic [QIW-1:0]      r_head, r_head_next;
  logic [CW-1:0]       r_cnt, r_cnt_next;
  status_t             res_status, res_status_next;
  logic                res_gv, res_gv_next;
  logic [NODE_W-1:0]   res_gnode, res_gnode_next;
  logic [LEFT_W-1:0]   res_left, res_left_next;

  // slot RAM
  logic              s_we;
  logic [SW-1:0]     s_raddr;
  logic [REC_W-1:0]  s_wdata, s_rdata;
  logic [KEY_W-1:0]  rd_key;
  logic              rd_held;
  logic [NODE_W-1:0] rd_holder;
  logic [QIW-1:0]    rd_head;
  logic [CW-1:0]     rd_cnt;

  // waiter RAM
  logic              w_we;
  logic [WAW-1:0]    w_addr, w_base;
  logic [NODE_W-1:0] w_rdata;

  logic              issue, hit;
  logic [SUMW-1:0]   enq_sum;
  logic [QIW-1:0]    enq_idx, head_inc;

  function automatic logic [LEFT_W-1:0] sat_left(input logic [CW-1:0] c);
    return (32'(c) > LEFT_MAX) ? LEFT_W'(LEFT_MAX) : LEFT_W'(c);
  endfunction

  assign {rd_key, rd_held, rd_holder, rd_head, rd_cnt} = s_rdata;
  assign s_wdata = {r_key_next, r_held_next, r_holder_next, r_head_next, r_cnt_next};
  assign in_stall = (state != ST_IDLE);

  assign issue    = (scan_idx < fill);
  assign hit      = pend && (rd_key == req_key);
  assign w_base   = WAW'(slot * QUEUE_DEPTH);
  assign enq_sum  = SUMW'(r_head) + SUMW'(r_cnt);
  assign enq_idx  = (enq_sum >= SUMW'(QUEUE_DEPTH)) ? QIW'(enq_sum - SUMW'(QUEUE_DEPTH))
                                                    : QIW'(enq_sum);
  assign head_inc = (r_head == QIW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

  flm_ram #(.W(REC_W), .D(NUM_SLOTS), .AW(SW)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (slot_next),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  flm_ram #(.W(NODE_W), .D(WD), .AW(WAW)) u_waiter_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_addr),
    .wdata (req_node),
    .raddr (w_addr),
    .rdata (w_rdata)
  );

  always_comb begin
    state_next      = state;
    act_next        = act;
    req_key_next    = req_key;
    req_node_next   = req_node;
    fill_next       = fill;
    scan_idx_next   = scan_idx;
    pend_next       = pend;
    cmp_idx_next    = cmp_idx;
    slot_next       = slot;
    r_key_next      = r_key;
    r_held_next     = r_held;
    r_holder_next   = r_holder;
    r_head_next     = r_head;
    r_cnt_next      = r_cnt;
    res_status_next = res_status;
    res_gv_next     = res_gv;
    res_gnode_next  = res_gnode;
    res_left_next   = res_left;
    s_we            = 1'b0;
    s_raddr         = scan_idx[SW-1:0];
    w_we            = 1'b0;
    w_addr          = w_base + WAW'(enq_idx);

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          act_next      = action;
          req_key_next  = lock_key;
          req_node_next = node;
          scan_idx_next = '0;
          pend_next     = 1'b0;
          state_next    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // read one slot a cycle, compare the one read last cycle
        pend_next = issue;
        if (issue) begin
          scan_idx_next = scan_idx + 1'b1;
          cmp_idx_next  = scan_idx[SW-1:0];
        end
        if (hit) begin
          slot_next     = cmp_idx;
          r_key_next    = rd_key;
          r_held_next   = rd_held;
          r_holder_next = rd_holder;
          r_head_next   = rd_head;
          r_cnt_next    = rd_cnt;
          state_next    = ST_EXEC;
        end else if (!issue && !pend) begin
          res_gv_next    = 1'b0;
          res_gnode_next = '0;
          res_left_next  = '0;
          if (act) begin
            res_status_next = STAT_NOT_FOUND;
            state_next      = ST_OUT;
          end else if (fill == FILL_W'(NUM_SLOTS)) begin
            res_status_next = STAT_TABLE_FULL;
            state_next      = ST_OUT;
          end else begin
            // claim the next slot; it is written back in EXEC
            slot_next   = fill[SW-1:0];
            fill_next   = fill + 1'b1;
            r_key_next  = req_key;
            r_held_next = 1'b0;
            r_head_next = '0;
            r_cnt_next  = '0;
            state_next  = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        state_next     = ST_OUT;
        res_gv_next    = 1'b0;
        res_gnode_next = '0;
        res_left_next  = sat_left(r_cnt);
        if (!act) begin
          if (!r_held) begin
            s_we            = 1'b1;
            r_held_next     = 1'b1;
            r_holder_next   = req_node;
            res_status_next = STAT_GRANTED;
            res_gv_next     = 1'b1;
            res_gnode_next  = req_node;
          end else if (r_cnt >= CW'(QUEUE_DEPTH)) begin
            res_status_next = STAT_QUEUE_FULL;
          end else begin
            w_we            = 1'b1;
            s_we            = 1'b1;
            r_cnt_next      = r_cnt + 1'b1;
            res_status_next = STAT_QUEUED;
            res_left_next   = sat_left(r_cnt + 1'b1);
          end
        end else begin
          if (!r_held || (r_holder != req_node)) begin
            res_status_next = STAT_NOT_HOLDER;
          end else if (r_cnt != '0) begin
            // fetch the oldest waiter
            w_addr     = w_base + WAW'(r_head);
            state_next = ST_POP;
          end else begin
            s_we            = 1'b1;
            r_held_next     = 1'b0;
            res_status_next = STAT_FREED;
            res_left_next   = '0;
          end
        end
      end
      ST_POP: begin
        s_we            = 1'b1;
        r_holder_next   = w_rdata;
        r_head_next     = head_inc;
        r_cnt_next      = r_cnt - 1'b1;
        res_status_next = STAT_PASSED;
        res_gv_next     = 1'b1;
        res_gnode_next  = w_rdata;
        res_left_next   = sat_left(r_cnt - 1'b1);
        state_next      = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      pend  <= pend_next;
      if (state == ST_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    act        <= act_next;
    req_key    <= req_key_next;
    req_node   <= req_node_next;
    scan_idx   <= scan_idx_next;
    cmp_idx    <= cmp_idx_next;
    slot       <= slot_next;
    r_key      <= r_key_next;
    r_held     <= r_held_next;
    r_holder   <= r_holder_next;
    r_head     <= r_head_next;
    r_cnt      <= r_cnt_next;
    res_status <= res_status_next;
    res_gv     <= res_gv_next;
    res_gnode  <= res_gnode_next;
    res_left   <= res_left_next;
    if (state == ST_OUT && (!out_valid || !out_stall)) begin
      status       <= res_status;
      grant_valid  <= res_gv;
      grant_node   <= res_gnode;
      waiters_left <= res_left;
    end
  end
endmodule
`default_nettype wire

// ----- sv/flm_checker.sv -----
// Port-level checks of the lock manager, bound to the top level.
// Depends on flm_pkg and fifo_lock_manager_macros.svh.
`default_nettype none
`include "fifo_lock_manager_macros.svh"
module flm_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [flm_pkg::STATUS_W-1:0]  status,
  input wire logic                          grant_valid,
  input wire logic [flm_pkg::NODE_W-1:0]    grant_node,
  input wire logic [flm_pkg::LEFT_W-1:0]    waiters_left
);
  import flm_pkg::*;

  `FLM_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "accepted word did not stall input")
  `FLM_ASSERT_NOW(a_grant_status, out_valid && grant_valid, status == STAT_GRANTED || status == STAT_PASSED, "grant without grant status")
  `FLM_ASSERT_NOW(a_no_slot_empty, out_valid && (status == STAT_NOT_FOUND || status == STAT_TABLE_FULL || status == STAT_FREED), waiters_left == '0 && !grant_valid, "slotless result carries data")
  `FLM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(grant_node), "stalled result changed")
endmodule

bind fifo_lock_manager flm_checker u_flm_checker (.*);
`default_nettype wire
